/* design/sc_pkg.sv */
// Shared constants, types and arctangent lookup for the spherical/Cartesian converter.
`timescale 1ns / 1ps
`default_nettype none

package sc_pkg;

    localparam int ANGLE_STAGES_DEF = 16;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint GAIN_Q30    = 64'sh26DD3B6A;
    localparam longint PI_Q16      = 64'sd205887;
    localparam longint RECIP_2PI   = (64'sd1 <<< 59) / TWO_PI_Q30;

    typedef struct packed {
        logic        kind;
        logic        zero_all;
        logic        zero_ab;
    } t_ctl;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_xyz;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic        zero;
        logic        sat;
    } t_res;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            5'd24:   v = 30'h0000003F;
            5'd25:   v = 30'h0000001F;
            5'd26:   v = 30'h0000000F;
            5'd27:   v = 30'h00000008;
            5'd28:   v = 30'h00000004;
            5'd29:   v = 30'h00000002;
            5'd30:   v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic ovf36(input logic [35:0] v);
        return !((v[35:31] == 5'b00000) || (v[35:31] == 5'b11111));
    endfunction

    function automatic logic [31:0] sat36(input logic [35:0] v);
        logic [31:0] r;
        if (!ovf36(v)) begin
            r = v[31:0];
        end else if (v[35]) begin
            r = 32'h80000000;
        end else begin
            r = 32'h7FFFFFFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/spherical_cartesian_convert.sv */
// Pipelined spherical/Cartesian point converter with CORDIC and square-root stages.
// Throughput: one beat per cycle while no finished beat is held at the output; the 32-step square root and
// the CORDIC chains set the depth. The whole pipeline holds while a finished beat waits at the output.
// Reset clears the valid bits only; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module spherical_cartesian_convert #(
    parameter int ANGLE_STAGES = sc_pkg::ANGLE_STAGES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_kind,
    input  wire logic signed [31:0] i_coord_a,
    input  wire logic signed [31:0] i_coord_b,
    input  wire logic signed [31:0] i_coord_c,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_out_a,
    output logic signed [31:0]      o_out_b,
    output logic signed [31:0]      o_out_c,
    output logic                    o_zero_radius,
    output logic                    o_saturated
);

    localparam int N      = ANGLE_STAGES;
    localparam int K1_END = N + 36;
    localparam int LAT    = N + 37;
    localparam int K0_DLY = 27;
    localparam int SQ_N   = 32;

    localparam logic signed [60:0] RECIP_61 = 61'(sc_pkg::RECIP_2PI);
    localparam logic signed [48:0] TWO_PI_49 = 49'(sc_pkg::TWO_PI_Q30);
    localparam logic signed [35:0] PI_36    = 36'(sc_pkg::PI_Q30);
    localparam logic signed [35:0] PI3_36   = 36'(3 * sc_pkg::PI_Q30);
    localparam logic signed [35:0] PI2_36   = 36'(sc_pkg::TWO_PI_Q30);
    localparam logic signed [35:0] PI4_36   = 36'(2 * sc_pkg::TWO_PI_Q30);
    localparam logic signed [33:0] PI_34    = 34'(sc_pkg::PI_Q30);
    localparam logic signed [33:0] HPI_34   = 34'(sc_pkg::HALF_PI_Q30);
    localparam logic signed [33:0] GAIN_34  = 34'(sc_pkg::GAIN_Q30);
    localparam logic signed [34:0] PI_35    = 35'(sc_pkg::PI_Q30);
    localparam logic signed [34:0] PIQ16_35 = 35'(sc_pkg::PI_Q16);

    logic                w_ce;
    logic [LAT:1]        r_vld;
    sc_pkg::t_ctl        r_ctl [1:K1_END];
    sc_pkg::t_res        r_out;

    // spherical to Cartesian lanes: 0 theta, 1 phi
    logic signed [31:0]  n_ang [2];
    logic signed [60:0]  n_pb [2];
    logic signed [48:0]  n_qm [2];
    logic signed [48:0]  n_rd [2];
    logic signed [60:0]  r_pb [2];
    logic signed [31:0]  r_ang [2];
    logic signed [35:0]  r_rd [2];
    logic signed [33:0]  r_nrm [2];
    logic signed [33:0]  r_rx [2][N+1];
    logic signed [33:0]  r_ry [2][N+1];
    logic signed [33:0]  r_rz [2][N+1];
    logic                r_neg [2][N+1];
    logic signed [31:0]  r_k0_a [1:N+7];
    logic signed [33:0]  r_cos [2];
    logic signed [33:0]  r_sin [2];
    logic signed [67:0]  r_p [2];
    logic signed [33:0]  r_ct6;
    logic signed [67:0]  n_pr [2];
    logic signed [33:0]  r_u [2];
    logic signed [33:0]  r_ct7;
    logic signed [65:0]  r_m [3];
    logic signed [65:0]  n_mr [3];
    sc_pkg::t_res        r_k0_res;
    sc_pkg::t_res        r_k0_dly [K0_DLY];

    // Cartesian to spherical
    logic signed [63:0]  n_sq [3];
    logic [62:0]         r_sq [3];
    sc_pkg::t_xyz        r_k1_in [1:34];
    logic [63:0]         n_xy;
    logic [63:0]         n_all;
    logic [63:0]         r_sq_n [2][SQ_N+1];
    logic [33:0]         r_rem [2][SQ_N+1];
    logic [31:0]         r_root [2][SQ_N+1];
    logic signed [59:0]  n_x0 [2];
    logic signed [59:0]  n_y0 [2];
    logic signed [59:0]  r_vx [2][N+1];
    logic signed [59:0]  r_vy [2][N+1];
    logic signed [34:0]  r_vz [2][N+1];
    logic [31:0]         r_rad [N+1];
    logic signed [34:0]  n_ts [2];
    logic signed [34:0]  n_th;
    logic signed [34:0]  n_ph;
    sc_pkg::t_res        r_k1_res;

    assign w_ce    = !r_vld[LAT] || i_ready;
    assign o_ready = w_ce;
    assign o_valid = r_vld[LAT];
    assign o_out_a = r_out.a;
    assign o_out_b = r_out.b;
    assign o_out_c = r_out.c;
    assign o_zero_radius = r_out.zero;
    assign o_saturated   = r_out.sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[LAT-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_ctl[1] <= '{kind:     i_kind,
                          zero_all: (i_coord_a == '0) && (i_coord_b == '0) && (i_coord_c == '0),
                          zero_ab:  (i_coord_a == '0) && (i_coord_b == '0)};
            for (int s = 2; s <= K1_END; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    // ---------------- angle reduction ----------------
    always_comb begin
        n_ang[0] = i_coord_b;
        n_ang[1] = i_coord_c;
        for (int l = 0; l < 2; l++) begin
            n_pb[l] = n_ang[l] * RECIP_61;
            n_qm[l] = $signed(r_pb[l][59:45]) * TWO_PI_49;
            n_rd[l] = $signed({{3{r_ang[l][31]}}, r_ang[l], 14'b0}) - n_qm[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_k0_a[1] <= i_coord_a;
            for (int s = 2; s <= N + 7; s++) begin
                r_k0_a[s] <= r_k0_a[s-1];
            end
            for (int l = 0; l < 2; l++) begin
                r_pb[l]  <= n_pb[l];
                r_ang[l] <= n_ang[l];
                r_rd[l]  <= n_rd[l][35:0];
                if (r_rd[l] > PI3_36) begin
                    r_nrm[l] <= 34'(r_rd[l] - PI4_36);
                end else if (r_rd[l] > PI_36) begin
                    r_nrm[l] <= 34'(r_rd[l] - PI2_36);
                end else if (r_rd[l] > -PI_36) begin
                    r_nrm[l] <= 34'(r_rd[l]);
                end else begin
                    r_nrm[l] <= 34'(r_rd[l] + PI2_36);
                end
                r_rx[l][0] <= GAIN_34;
                r_ry[l][0] <= '0;
                if (r_nrm[l] > HPI_34) begin
                    r_rz[l][0]  <= r_nrm[l] - PI_34;
                    r_neg[l][0] <= 1'b1;
                end else if (r_nrm[l] < -HPI_34) begin
                    r_rz[l][0]  <= r_nrm[l] + PI_34;
                    r_neg[l][0] <= 1'b1;
                end else begin
                    r_rz[l][0]  <= r_nrm[l];
                    r_neg[l][0] <= 1'b0;
                end
            end
        end
    end

    // ---------------- rotation CORDIC ----------------
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int l = 0; l < 2; l++) begin
                for (int i = 0; i < N; i++) begin
                    r_neg[l][i+1] <= r_neg[l][i];
                    if (!r_rz[l][i][33]) begin
                        r_rx[l][i+1] <= r_rx[l][i] - (r_ry[l][i] >>> i);
                        r_ry[l][i+1] <= r_ry[l][i] + (r_rx[l][i] >>> i);
                        r_rz[l][i+1] <= r_rz[l][i]
                                        - $signed({4'b0, sc_pkg::atan_q30(5'(i))});
                    end else begin
                        r_rx[l][i+1] <= r_rx[l][i] + (r_ry[l][i] >>> i);
                        r_ry[l][i+1] <= r_ry[l][i] - (r_rx[l][i] >>> i);
                        r_rz[l][i+1] <= r_rz[l][i]
                                        + $signed({4'b0, sc_pkg::atan_q30(5'(i))});
                    end
                end
            end
        end
    end

    // ---------------- products ----------------
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_pr[l] = r_p[l] + 68'sd536870912;
        end
        for (int k = 0; k < 3; k++) begin
            n_mr[k] = r_m[k] + 66'sd536870912;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int l = 0; l < 2; l++) begin
                r_cos[l] <= r_neg[l][N] ? -r_rx[l][N] : r_rx[l][N];
                r_sin[l] <= r_neg[l][N] ? -r_ry[l][N] : r_ry[l][N];
                r_u[l]   <= $signed(n_pr[l][63:30]);
            end
            r_p[0] <= r_sin[0] * r_cos[1];
            r_p[1] <= r_sin[0] * r_sin[1];
            r_ct6  <= r_cos[0];
            r_ct7  <= r_ct6;
            r_m[0] <= r_k0_a[N+7] * r_u[0];
            r_m[1] <= r_k0_a[N+7] * r_u[1];
            r_m[2] <= r_k0_a[N+7] * r_ct7;
            r_k0_res.a    <= sc_pkg::sat36(n_mr[0][65:30]);
            r_k0_res.b    <= sc_pkg::sat36(n_mr[1][65:30]);
            r_k0_res.c    <= sc_pkg::sat36(n_mr[2][65:30]);
            r_k0_res.zero <= 1'b0;
            r_k0_res.sat  <= sc_pkg::ovf36(n_mr[0][65:30]) || sc_pkg::ovf36(n_mr[1][65:30])
                             || sc_pkg::ovf36(n_mr[2][65:30]);
            r_k0_dly[0] <= r_k0_res;
            for (int k = 1; k < K0_DLY; k++) begin
                r_k0_dly[k] <= r_k0_dly[k-1];
            end
        end
    end

    // ---------------- squares and square roots ----------------
    always_comb begin
        n_sq[0] = i_coord_a * i_coord_a;
        n_sq[1] = i_coord_b * i_coord_b;
        n_sq[2] = i_coord_c * i_coord_c;
        n_xy    = {1'b0, r_sq[0]} + {1'b0, r_sq[1]};
        n_all   = n_xy + {1'b0, r_sq[2]};
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= n_sq[k][62:0];
            end
            r_k1_in[1] <= {i_coord_a, i_coord_b, i_coord_c};
            for (int s = 2; s <= 34; s++) begin
                r_k1_in[s] <= r_k1_in[s-1];
            end
            r_sq_n[0][0] <= n_xy;
            r_sq_n[1][0] <= n_all;
            for (int l = 0; l < 2; l++) begin
                r_rem[l][0]  <= '0;
                r_root[l][0] <= '0;
                for (int j = 0; j < SQ_N; j++) begin
                    r_sq_n[l][j+1] <= {r_sq_n[l][j][61:0], 2'b00};
                    if ({r_rem[l][j], r_sq_n[l][j][63:62]}
                            >= {2'b00, r_root[l][j], 2'b01}) begin
                        r_rem[l][j+1]  <= 34'({r_rem[l][j], r_sq_n[l][j][63:62]}
                                              - {2'b00, r_root[l][j], 2'b01});
                        r_root[l][j+1] <= {r_root[l][j][30:0], 1'b1};
                    end else begin
                        r_rem[l][j+1]  <= {r_rem[l][j][31:0], r_sq_n[l][j][63:62]};
                        r_root[l][j+1] <= {r_root[l][j][30:0], 1'b0};
                    end
                end
            end
        end
    end

    // ---------------- vectoring CORDIC ----------------
    always_comb begin
        n_x0[0] = $signed({{4{r_k1_in[34].c[31]}}, r_k1_in[34].c, 24'b0});
        n_y0[0] = $signed({4'b0, r_root[0][SQ_N], 24'b0});
        n_x0[1] = $signed({{4{r_k1_in[34].a[31]}}, r_k1_in[34].a, 24'b0});
        n_y0[1] = $signed({{4{r_k1_in[34].b[31]}}, r_k1_in[34].b, 24'b0});
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_rad[0] <= r_root[1][SQ_N];
            for (int i = 0; i < N; i++) begin
                r_rad[i+1] <= r_rad[i];
            end
            for (int l = 0; l < 2; l++) begin
                if (n_x0[l][59]) begin
                    r_vz[l][0] <= n_y0[l][59] ? -PI_35 : PI_35;
                    r_vx[l][0] <= -n_x0[l];
                    r_vy[l][0] <= -n_y0[l];
                end else begin
                    r_vz[l][0] <= '0;
                    r_vx[l][0] <= n_x0[l];
                    r_vy[l][0] <= n_y0[l];
                end
                for (int i = 0; i < N; i++) begin
                    if (!r_vy[l][i][59] && (r_vy[l][i] != '0)) begin
                        r_vx[l][i+1] <= r_vx[l][i] + (r_vy[l][i] >>> i);
                        r_vy[l][i+1] <= r_vy[l][i] - (r_vx[l][i] >>> i);
                        r_vz[l][i+1] <= r_vz[l][i]
                                        + $signed({5'b0, sc_pkg::atan_q30(5'(i))});
                    end else begin
                        r_vx[l][i+1] <= r_vx[l][i] - (r_vy[l][i] >>> i);
                        r_vy[l][i+1] <= r_vy[l][i] + (r_vx[l][i] >>> i);
                        r_vz[l][i+1] <= r_vz[l][i]
                                        - $signed({5'b0, sc_pkg::atan_q30(5'(i))});
                    end
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_ts[l] = (r_vz[l][N] + 35'sd8192) >>> 14;
        end
        if (n_ts[0][34]) begin
            n_th = '0;
        end else if (n_ts[0] > PIQ16_35) begin
            n_th = PIQ16_35;
        end else begin
            n_th = n_ts[0];
        end
        if (r_ctl[N+35].zero_ab) begin
            n_ph = '0;
        end else if (n_ts[1] > PIQ16_35) begin
            n_ph = PIQ16_35;
        end else if (n_ts[1] < -PIQ16_35) begin
            n_ph = -PIQ16_35;
        end else begin
            n_ph = n_ts[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_k1_res.a    <= r_rad[N][31] ? 32'h7FFFFFFF : r_rad[N];
            r_k1_res.b    <= n_th[31:0];
            r_k1_res.c    <= n_ph[31:0];
            r_k1_res.zero <= 1'b0;
            r_k1_res.sat  <= r_rad[N][31];
            if (!r_ctl[K1_END].kind) begin
                r_out <= r_k0_dly[K0_DLY-1];
            end else if (r_ctl[K1_END].zero_all) begin
                r_out <= '{a: '0, b: '0, c: '0, zero: 1'b1, sat: 1'b0};
            end else begin
                r_out <= r_k1_res;
            end
        end
    end

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[1])
        else $error("accepted beat did not enter the pipeline");

    a_origin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_radius |->
            (o_out_a == '0) && (o_out_b == '0) && (o_out_c == '0) && !o_saturated)
        else $error("origin result carries nonzero fields");

endmodule

`default_nettype wire

/* tb/spherical_cartesian_convert_tb.sv */
// Self-checking testbench for the spherical/Cartesian converter: table plus random beats.
`timescale 1ns / 1ps

module spherical_cartesian_convert_tb;

    localparam int    N_STAGES    = sc_pkg::ANGLE_STAGES_DEF;
    localparam int    N_RANDOM    = 930;
    localparam int    QUIET_TAIL  = 120;
    localparam int    LONG_HOLD   = 400;
    localparam int    DRAIN_WAIT  = 80;
    localparam int    STALL_LIMIT = 3000;
    localparam int    KIND_TO_XYZ = 0;
    localparam int    KIND_TO_SPH = 1;
    localparam longint ANGLE_SPAN = 823548;

    localparam longint ATAN_TAB [0:31] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000
    };

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic        zero;
        logic        sat;
    } point_t;

    typedef struct {
        logic        kind;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        bit          typed;
        point_t      res;
    } row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_kind = 1'b0;
    logic signed [31:0] i_coord_a = '0;
    logic signed [31:0] i_coord_b = '0;
    logic signed [31:0] i_coord_c = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_out_a;
    logic signed [31:0] o_out_b;
    logic signed [31:0] o_out_c;
    logic               o_zero_radius;
    logic               o_saturated;

    point_t pending_points[$];
    int     n_errors = 0;
    int     idle_cycles = 0;
    bit     quiet = 1'b0;
    bit     long_hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    spherical_cartesian_convert #(.ANGLE_STAGES(N_STAGES)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_coord_a(i_coord_a), .i_coord_b(i_coord_b),
        .i_coord_c(i_coord_c),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_out_a(o_out_a), .o_out_b(o_out_b), .o_out_c(o_out_c),
        .o_zero_radius(o_zero_radius), .o_saturated(o_saturated)
    );

    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip32(input longint v, inout bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bsel;
        res = '0;
        bsel = 64'd1 << 62;
        while (bsel > n) bsel = bsel >> 2;
        while (bsel != 0) begin
            if (n >= res + bsel) begin
                n = n - (res + bsel);
                res = (res >> 1) + bsel;
            end else begin
                res = res >> 1;
            end
            bsel = bsel >> 2;
        end
        return res;
    endfunction

    function automatic void rotate_angle(input longint ang, output longint cs,
                                         output longint sn);
        longint a, x, y, t;
        bit     flip;
        a = ang % sc_pkg::TWO_PI_Q30;
        x = sc_pkg::GAIN_Q30;
        y = 0;
        flip = 1'b0;
        if (a > sc_pkg::PI_Q30) a = a - sc_pkg::TWO_PI_Q30;
        if (a < -sc_pkg::PI_Q30) a = a + sc_pkg::TWO_PI_Q30;
        if (a > sc_pkg::HALF_PI_Q30) begin
            a = a - sc_pkg::PI_Q30;
            flip = 1'b1;
        end else if (a < -sc_pkg::HALF_PI_Q30) begin
            a = a + sc_pkg::PI_Q30;
            flip = 1'b1;
        end
        for (int i = 0; i < N_STAGES; i++) begin
            t = x;
            if (a >= 0) begin
                x = x - (y >>> i);
                y = y + (t >>> i);
                a = a - ATAN_TAB[i % 32];
            end else begin
                x = x + (y >>> i);
                y = y - (t >>> i);
                a = a + ATAN_TAB[i % 32];
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic longint vector_angle(input longint py, input longint px);
        longint x, y, z, t;
        x = px * (64'sd1 <<< 24);
        y = py * (64'sd1 <<< 24);
        z = 0;
        if (px == 0 && py == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? sc_pkg::PI_Q30 : -sc_pkg::PI_Q30;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < N_STAGES; i++) begin
            t = x;
            if (y > 0) begin
                x = x + (y >>> i);
                y = y - (t >>> i);
                z = z + ATAN_TAB[i % 32];
            end else begin
                x = x - (y >>> i);
                y = y + (t >>> i);
                z = z - ATAN_TAB[i % 32];
            end
        end
        return z;
    endfunction

    function automatic point_t convert_point(input logic kind, input logic [31:0] ia,
                                             input logic [31:0] ib, input logic [31:0] ic);
        point_t      p;
        longint      a, b, c, ct, st, cp, sp, ra, rb, rc, rho;
        logic [63:0] xy, r;
        bit          sat;
        a = longint'($signed(ia));
        b = longint'($signed(ib));
        c = longint'($signed(ic));
        sat = 1'b0;
        p.zero = 1'b0;
        if (kind == KIND_TO_XYZ) begin
            rotate_angle(b * 16384, ct, st);
            rotate_angle(c * 16384, cp, sp);
            ra = clip32(rnd_shift(a * rnd_shift(st * cp, 30), 30), sat);
            rb = clip32(rnd_shift(a * rnd_shift(st * sp, 30), 30), sat);
            rc = clip32(rnd_shift(a * ct, 30), sat);
        end else if (a == 0 && b == 0 && c == 0) begin
            ra = 0;
            rb = 0;
            rc = 0;
            p.zero = 1'b1;
        end else begin
            xy = 64'(a * a) + 64'(b * b);
            r = root_floor(xy + 64'(c * c));
            rho = longint'(root_floor(xy));
            if (r > 64'h7FFFFFFF) begin
                r = 64'h7FFFFFFF;
                sat = 1'b1;
            end
            ra = longint'(r);
            rb = clamp_to(rnd_shift(vector_angle(rho, c), 14), 0, sc_pkg::PI_Q16);
            rc = (a == 0 && b == 0) ? 0
               : clamp_to(rnd_shift(vector_angle(b, a), 14), -sc_pkg::PI_Q16,
                          sc_pkg::PI_Q16);
        end
        p.a = ra[31:0];
        p.b = rb[31:0];
        p.c = rc[31:0];
        p.sat = sat;
        return p;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
        n_errors++;
    endtask

    task automatic send_beat(input logic kind, input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input bit typed, input point_t res);
        int gap;
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_coord_a <= a;
        i_coord_b <= b;
        i_coord_c <= c;
        do @(posedge i_clk); while (!o_ready);
        pending_points.push_back(typed ? res : convert_point(kind, a, b, c));
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_coord(input int max_sh);
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, max_sh);
    endfunction

    function automatic logic [31:0] rand_angle();
        longint v;
        if ($urandom_range(0, 9) == 0) return $urandom;
        v = longint'($urandom_range(0, 2 * ANGLE_SPAN)) - ANGLE_SPAN;
        return v[31:0];
    endfunction

    // receiver: random hold bursts, one long hold on request, none in the tail
    initial begin
        int hold;
        int gap;
        hold = 0;
        gap = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else if (quiet) begin
                i_ready <= 1'b1;
            end else if (gap > 0) begin
                gap--;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 5) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        point_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected beat", o_out_a, 0);
            end else begin
                want = pending_points.pop_front();
                if (o_out_a !== want.a) report_mismatch("out_a", o_out_a, want.a);
                if (o_out_b !== want.b) report_mismatch("out_b", o_out_b, want.b);
                if (o_out_c !== want.c) report_mismatch("out_c", o_out_c, want.c);
                if (o_zero_radius !== want.zero)
                    report_mismatch("zero_radius", o_zero_radius, want.zero);
                if (o_saturated !== want.sat)
                    report_mismatch("saturated", o_saturated, want.sat);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        row_t   rows[$];
        point_t none;
        row_t   r;
        logic   kind;
        logic [31:0] a, b, c;
        none = '{a: '0, b: '0, c: '0, zero: 1'b0, sat: 1'b0};

        rows.push_back('{1'b1, 32'h0, 32'h0, 32'h0, 1'b1,
                         '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0}});
        rows.push_back('{1'b0, 32'h0, 32'h0, 32'h0, 1'b1,
                         '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0}});
        rows.push_back('{1'b0, 32'h0, 32'h7FFFFFFF, 32'h80000000, 1'b1,
                         '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0}});
        rows.push_back('{1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, none});
        rows.push_back('{1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, none});
        rows.push_back('{1'b0, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b0, none});
        rows.push_back('{1'b0, 32'h80000000, 32'h0, 32'h0, 1'b0, none});
        rows.push_back('{1'b0, 32'h00010000, 32'd205887, 32'hFFFCDBC1, 1'b0, none});
        rows.push_back('{1'b0, 32'h00050000, 32'd102944, 32'd102944, 1'b0, none});
        rows.push_back('{1'b0, 32'hFFFB0000, 32'd51472, 32'd154415, 1'b0, none});
        rows.push_back('{1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, none});
        rows.push_back('{1'b1, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, none});
        rows.push_back('{1'b1, 32'h0, 32'h0, 32'h00030000, 1'b0, none});
        rows.push_back('{1'b1, 32'h0, 32'h0, 32'hFFFD0000, 1'b0, none});
        rows.push_back('{1'b1, 32'hFFFF0000, 32'h0, 32'h0, 1'b0, none});
        rows.push_back('{1'b1, 32'hFFFF0000, 32'hFFFF0000, 32'h00010000, 1'b0, none});
        rows.push_back('{1'b1, 32'h00010000, 32'h0, 32'h0, 1'b0, none});
        rows.push_back('{1'b1, 32'h0, 32'h00010000, 32'h0, 1'b0, none});
        rows.push_back('{1'b1, 32'h0, 32'hFFFF0000, 32'h0, 1'b0, none});
        rows.push_back('{1'b1, 32'h00000001, 32'h00000001, 32'h00000001, 1'b0, none});
        rows.push_back('{1'b1, 32'h80000000, 32'h0, 32'h0, 1'b0, none});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            r = rows[i];
            send_beat(r.kind, r.a, r.b, r.c, r.typed, r.res);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 250) long_hold_req = 1'b1;
            if (n == 600) begin
                i_valid <= 1'b0;
                while (pending_points.size() > 0) @(posedge i_clk);
            end
            if (n == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
            kind = $urandom_range(0, 1);
            if ($urandom_range(0, 9) == 0) begin
                a = $urandom;
                b = $urandom;
                c = $urandom;
            end else if (kind == KIND_TO_XYZ) begin
                a = rand_coord(31);
                if ($urandom_range(0, 3) != 0) a = {1'b0, a[30:0]};
                b = rand_angle();
                c = rand_angle();
            end else begin
                a = rand_coord(31);
                b = rand_coord(31);
                c = rand_coord(31);
                case ($urandom_range(0, 7))
                    0: begin
                        a = '0;
                        b = '0;
                    end
                    1: a = '0;
                    2: b = '0;
                    3: c = '0;
                    default: ;
                endcase
            end
            send_beat(kind, a, b, c, 1'b0, none);
        end
        i_valid <= 1'b0;

        while (pending_points.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
design/sc_pkg.sv
design/spherical_cartesian_convert.sv
tb/spherical_cartesian_convert_tb.sv
